// ----- hw/rtl/sfpd_pkg.sv -----
package sfpd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h81;
  localparam logic [7:0] SYNC_SECOND = 8'hA1;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ID    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CK0   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CK1   = 3'd6;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_ID_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD255   = 1'd1;

  localparam logic [8:0] ID_LIMIT_RESET = 9'd256;
  localparam logic [8:0] MOD255_VALUE   = 9'd255;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_id;
    logic [7:0] payload_length;
    logic       status;
    logic       last;
  } sfpd_result_t;

  function automatic logic [7:0] sfpd_mod_add(input logic [7:0] a, input logic [7:0] b,
                                              input logic mod255);
    logic [8:0] s;
    logic [8:0] t;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (mod255) begin
        t = (s >= MOD255_VALUE) ? s - MOD255_VALUE : s;
        t = (t >= MOD255_VALUE) ? t - MOD255_VALUE : t;
      end else begin
        t = s;
      end
      return t[7:0];
    end
  endfunction

endpackage

// ----- hw/rtl/sync_framed_packet_deframer_unit.sv -----
// Sync-framed packet deframer with a two-byte Fletcher-style check.
// Input channel: one received byte per beat (in_valid, in_stall, in_rx_byte).
// The block hunts for 0x81 then 0xA1, reads a message ID and a length byte,
// forwards each payload byte as one result beat (kind 0) and, after the two
// check bytes, gives one end beat (kind 1, last 1) whose status is 1 on a
// checksum mismatch. IDs at or above the configured ID limit are dropped silently.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 ID limit, 1 modulus
// mode) and cfg_data; cfg_ready is always high; write only while idle.
// A result beat is registered from its input byte as that byte is accepted;
// under out_stall it goes into the skid register. Throughput: one byte per
// cycle while in_stall is low, set by the input-to-result state update.
// Stall: a result waiting on out_stall is held; one further result goes into
// a skid register, and only while that register is full is in_stall high.
// Reset (rst_n low, synchronous): hunting for the first sync byte, sums and
// held fields zero, limit 256, modulus 256, no result pending. No clearing
// pass is needed.
module sync_framed_packet_deframer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [7:0]                       out_byte_index,
  output logic [7:0]                       out_frame_id,
  output logic [7:0]                       out_payload_length,
  output logic                             out_status,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfpd_pkg::*;

  logic [8:0]         id_limit_r;
  logic               mod255_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         sum_a_r, sum_a_nxt;
  logic [7:0]         sum_b_r, sum_b_nxt;
  logic [7:0]         held_id_r, held_id_nxt;
  logic [7:0]         held_len_r, held_len_nxt;
  logic [7:0]         seen_r, seen_nxt;
  logic [7:0]         ck0_r, ck0_nxt;
  logic               res_vld;
  sfpd_result_t       res;
  logic               out_vld_r;
  sfpd_result_t       out_r;
  logic               skid_vld_r;
  sfpd_result_t       skid_r;
  logic               in_acc;
  logic [7:0]         add_a;
  logic [7:0]         add_b;
  logic [7:0]         seen_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !skid_vld_r;

  assign add_a    = sfpd_mod_add(sum_a_r, in_rx_byte, mod255_r);
  assign add_b    = sfpd_mod_add(sum_b_r, add_a, mod255_r);
  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    held_id_nxt  = held_id_r;
    held_len_nxt = held_len_r;
    seen_nxt     = seen_r;
    ck0_nxt      = ck0_r;
    res_vld      = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.byte_index     = 8'd0;
    res.frame_id       = held_id_r;
    res.payload_length = held_len_r;
    res.status         = 1'b0;
    res.last           = 1'b0;
    case (phase_r)
      PH_HUNT2: begin
        if (in_rx_byte == SYNC_SECOND) begin
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
          phase_nxt = PH_ID;
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_ID: begin
        if ({1'b0, in_rx_byte} >= id_limit_r) begin
          phase_nxt = PH_HUNT1;
        end else begin
          held_id_nxt = in_rx_byte;
          sum_a_nxt   = add_a;
          sum_b_nxt   = add_b;
          phase_nxt   = PH_LEN;
        end
      end
      PH_LEN: begin
        held_len_nxt = in_rx_byte;
        seen_nxt     = 8'd0;
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        phase_nxt    = (in_rx_byte == 8'd0) ? PH_CK0 : PH_DATA;
      end
      PH_DATA: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        res_vld          = 1'b1;
        res.payload_byte = in_rx_byte;
        res.byte_index   = seen_r;
        seen_nxt         = seen_inc;
        if (seen_inc == held_len_r) begin
          phase_nxt = PH_CK0;
        end
      end
      PH_CK0: begin
        ck0_nxt   = in_rx_byte;
        phase_nxt = PH_CK1;
      end
      PH_CK1: begin
        res_vld    = 1'b1;
        res.kind   = KIND_END;
        res.status = (ck0_r != sum_a_r) || (in_rx_byte != sum_b_r);
        res.last   = 1'b1;
        phase_nxt  = PH_HUNT1;
      end
      default: begin
        phase_nxt = (in_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= ID_LIMIT_RESET;
      mod255_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ID_LIMIT: id_limit_r <= cfg_data;
        REG_MOD255:   mod255_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT1;
      sum_a_r    <= 8'd0;
      sum_b_r    <= 8'd0;
      held_id_r  <= 8'd0;
      held_len_r <= 8'd0;
      seen_r     <= 8'd0;
      ck0_r      <= 8'd0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      held_id_r  <= held_id_nxt;
      held_len_r <= held_len_nxt;
      seen_r     <= seen_nxt;
      ck0_r      <= ck0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_stall) begin
      if (in_acc && res_vld) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_acc && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && out_stall) begin
      if (in_acc && res_vld) begin
        skid_r <= res;
      end
    end else if (skid_vld_r) begin
      out_r <= skid_r;
    end else if (in_acc && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = out_r.kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_byte_index     = out_r.byte_index;
  assign out_frame_id       = out_r.frame_id;
  assign out_payload_length = out_r.payload_length;
  assign out_status         = out_r.status;
  assign out_last           = out_r.last;

endmodule

// ----- hw/rtl/sfpd_checker.sv -----
module sfpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_byte_index,
  input logic       out_status,
  input logic       out_last
);
  import sfpd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_END) |->
      (out_last && out_payload_byte == 8'd0 && out_byte_index == 8'd0))
    else $error("malformed end beat");

  a_payload_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAYLOAD) |-> (!out_last && !out_status))
    else $error("payload beat carries end flags");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_kind) && $stable(out_payload_byte) &&
       $stable(out_byte_index) && $stable(out_status)))
    else $error("stalled result beat changed");

endmodule

bind sync_framed_packet_deframer_unit sfpd_checker u_sfpd_checker (.*);

// ----- verif/tb.sv -----
import sfpd_pkg::*;

class deframer_scoreboard;
  logic [8:0]   id_limit;
  logic         mod255;
  logic [2:0]   phase;
  logic [7:0]   sum_a;
  logic [7:0]   sum_b;
  logic [7:0]   pkt_id;
  logic [7:0]   pkt_len;
  logic [7:0]   pkt_pos;
  logic [7:0]   check_hi;
  sfpd_result_t awaited[$];
  int           errors;

  function new();
    id_limit = ID_LIMIT_RESET;
    mod255   = 1'b0;
    phase    = PH_HUNT1;
    sum_a    = '0;
    sum_b    = '0;
    pkt_id   = '0;
    pkt_len  = '0;
    pkt_pos  = '0;
    check_hi = '0;
    errors   = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    if (idx == REG_ID_LIMIT) begin
      id_limit = d;
    end else if (idx == REG_MOD255) begin
      mod255 = d[0];
    end
  endfunction

  function void fold(logic [7:0] b);
    int m;
    m = mod255 ? 255 : 256;
    sum_a = 8'((int'(sum_a) + int'(b)) % m);
    sum_b = 8'((int'(sum_b) + int'(sum_a)) % m);
  endfunction

  function void note_beat(logic [7:0] b);
    sfpd_result_t r;
    r.frame_id       = pkt_id;
    r.payload_length = pkt_len;
    case (phase)
      PH_HUNT2: begin
        if (b == SYNC_SECOND) begin
          sum_a = '0;
          sum_b = '0;
          phase = PH_ID;
        end else begin
          phase = PH_HUNT1;
        end
      end
      PH_ID: begin
        if ({1'b0, b} >= id_limit) begin
          phase = PH_HUNT1;
        end else begin
          pkt_id = b;
          fold(b);
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        pkt_len = b;
        pkt_pos = '0;
        fold(b);
        phase = (b == 8'd0) ? PH_CK0 : PH_DATA;
      end
      PH_DATA: begin
        fold(b);
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = pkt_pos;
        r.status       = 1'b0;
        r.last         = 1'b0;
        awaited.push_back(r);
        pkt_pos = pkt_pos + 8'd1;
        if (pkt_pos == pkt_len) phase = PH_CK0;
      end
      PH_CK0: begin
        check_hi = b;
        phase = PH_CK1;
      end
      PH_CK1: begin
        r.kind         = KIND_END;
        r.payload_byte = '0;
        r.byte_index   = '0;
        r.status       = (check_hi != sum_a) || (b != sum_b);
        r.last         = 1'b1;
        awaited.push_back(r);
        phase = PH_HUNT1;
      end
      default: begin
        phase = (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  endfunction

  function void compare(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_beat(sfpd_result_t got);
    sfpd_result_t want;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: beat with none expected, expected nothing actual kind %0h byte %0h",
               $time, got.kind, got.payload_byte);
      return;
    end
    want = awaited.pop_front();
    compare("kind", want.kind, got.kind);
    compare("payload_byte", want.payload_byte, got.payload_byte);
    compare("byte_index", want.byte_index, got.byte_index);
    compare("frame_id", want.frame_id, got.frame_id);
    compare("payload_length", want.payload_length, got.payload_length);
    compare("status", want.status, got.status);
    compare("last", want.last, got.last);
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [7:0]            out_payload_byte;
  logic [7:0]            out_byte_index;
  logic [7:0]            out_frame_id;
  logic [7:0]            out_payload_length;
  logic                  out_status;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  deframer_scoreboard sb = new();
  int sent_bytes = 0;
  int idle_pct = 20;
  int stall_pct = 17;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  sync_framed_packet_deframer_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_byte_index     (out_byte_index),
    .out_frame_id       (out_frame_id),
    .out_payload_length (out_payload_length),
    .out_status         (out_status),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : result_side
    sfpd_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind           = out_kind;
      got.payload_byte   = out_payload_byte;
      got.byte_index     = out_byte_index;
      got.frame_id       = out_frame_id;
      got.payload_length = out_payload_length;
      got.status         = out_status;
      got.last           = out_last;
      sb.check_beat(got);
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
    sent_bytes++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_packet(logic [7:0] id, logic [7:0] len, bit spoil);
    int m;
    int a;
    int c;
    logic [7:0] p;
    logic [7:0] ck0;
    logic [7:0] ck1;
    m = sb.mod255 ? 255 : 256;
    a = 0;
    c = 0;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(id);
    a = (a + id) % m;
    c = (c + a) % m;
    send_byte(len);
    a = (a + len) % m;
    c = (c + a) % m;
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(255));
      send_byte(p);
      a = (a + p) % m;
      c = (c + a) % m;
    end
    ck0 = 8'(a);
    ck1 = 8'(c);
    if (spoil) begin
      if ($urandom_range(1)) ck0 = ck0 ^ (8'd1 << $urandom_range(7));
      else ck1 = ck1 ^ (8'd1 << $urandom_range(7));
    end
    send_byte(ck0);
    send_byte(ck1);
  endtask

  task automatic random_traffic(int target);
    int stop_at;
    int r;
    int lim;
    logic [7:0] id;
    logic [7:0] len;
    stop_at = sent_bytes + target;
    lim = (sb.id_limit > 256) ? 256 : int'(sb.id_limit);
    while (sent_bytes < stop_at) begin
      r = $urandom_range(99);
      if (lim > 0 && $urandom_range(3) != 0) id = 8'($urandom_range(lim - 1));
      else id = 8'($urandom_range(255));
      if (r < 72) begin
        r = $urandom_range(99);
        if (r < 2) len = 8'd255;
        else if (r < 12) len = 8'($urandom_range(7, 40));
        else len = 8'($urandom_range(0, 6));
        send_packet(id, len, $urandom_range(99) < 15);
      end else if (r < 82) begin
        send_byte(SYNC_FIRST);
        send_byte(8'($urandom_range(255)) == SYNC_SECOND ? SYNC_FIRST
                                                          : 8'($urandom_range(255)));
      end else if (r < 90) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(lim < 256 ? 8'($urandom_range(lim, 255)) : id);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  int limits[6] = '{256, 255, 0, 128, 1, 256};
  int mods[6]   = '{0, 1, 0, 1, 1, 0};
  int sizes[6]  = '{380, 380, 60, 380, 300, 380};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_packet(8'hFF, 8'd0, 1'b0);
    drain();
    write_reg(REG_ID_LIMIT, 9'h010);
    write_reg(REG_MOD255, 9'd1);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h10);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h0F);
    send_byte(8'd2);
    send_byte(8'hFF);
    drain();
    write_reg(REG_MOD255, 9'd0);
    send_byte(8'h00);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_ID_LIMIT, CFG_DATA_W'(limits[ph]));
      write_reg(REG_MOD255, CFG_DATA_W'(mods[ph]));
      idle_pct  = (ph == 5) ? 0 : 20;
      stall_pct = (ph == 5) ? 0 : 17;
      if (ph == 0) begin
        hold_reqs++;
        send_packet(8'($urandom_range(255)), 8'd40, 1'b0);
      end
      random_traffic(sizes[ph]);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
